[design/qrt_pkg.sv]
// Package for the query retransmit tracker: status codes, commands, config indexes.
// No dependencies.
package qrt_pkg;

  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_POLL   = 2'd1;
  localparam logic [1:0] CMD_RESP   = 2'd2;
  localparam logic [1:0] CMD_NOTICE = 2'd3;

  localparam logic [3:0] ST_ACCEPTED  = 4'd0;
  localparam logic [3:0] ST_NO_ID     = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_IDLE      = 4'd3;
  localparam logic [3:0] ST_SENT      = 4'd4;
  localparam logic [3:0] ST_RETRY     = 4'd5;
  localparam logic [3:0] ST_TOO_LONG  = 4'd6;
  localparam logic [3:0] ST_POSTED    = 4'd7;
  localparam logic [3:0] ST_UNKNOWN   = 4'd8;
  localparam logic [3:0] ST_RESP_LONG = 4'd9;
  localparam logic [3:0] ST_SHORT     = 4'd10;
  localparam logic [3:0] ST_NOTICE    = 4'd11;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_REPEAT   = 2'd1;
  localparam logic [1:0] CFG_MAXLEN   = 2'd2;

  localparam int unsigned CNT_MAX = 511;

endpackage

[design/qrt_front.sv]
// Front end of the query retransmit tracker: command intake and one-entry queue.
// Depends on qrt_pkg.
module qrt_front import qrt_pkg::*; #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  input  logic [15:0]           in_query_handle,
  input  logic [15:0]           in_query_length,
  input  logic [15:0]           in_response_limit,
  input  logic [15:0]           in_response_id,
  input  logic [15:0]           in_packet_length,
  input  logic                  back_take,
  output logic                  q_valid,
  output logic [1:0]            q_command,
  output logic [TIME_WIDTH-1:0] q_now_time,
  output logic [15:0]           q_query_handle,
  output logic [15:0]           q_query_length,
  output logic [15:0]           q_response_limit,
  output logic [15:0]           q_response_id,
  output logic [15:0]           q_packet_length,
  output logic                  q_short
);

  logic                  q_valid_r;
  logic [1:0]            cmd_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [15:0]           hnd_r, qlen_r, rlim_r, rid_r, plen_r;
  logic                  short_r;

  assign busy = q_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (start && !q_valid_r) begin
      q_valid_r <= 1'b1;
    end else if (back_take) begin
      q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !q_valid_r) begin
      cmd_r   <= in_command;
      now_r   <= in_now_time;
      hnd_r   <= in_query_handle;
      qlen_r  <= in_query_length;
      rlim_r  <= in_response_limit;
      rid_r   <= in_response_id;
      plen_r  <= in_packet_length;
      short_r <= (in_packet_length < 16'd2);
    end
  end

  assign q_valid          = q_valid_r;
  assign q_command        = cmd_r;
  assign q_now_time       = now_r;
  assign q_query_handle   = hnd_r;
  assign q_query_length   = qlen_r;
  assign q_response_limit = rlim_r;
  assign q_response_id    = rid_r;
  assign q_packet_length  = plen_r;
  assign q_short          = short_r;

endmodule

[design/qrt_back.sv]
// Back end of the query retransmit tracker: slot table, scan sequencer, results.
// Depends on qrt_pkg.
module qrt_back import qrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_TRIES    = 4,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [1:0]            q_command,
  input  logic [TIME_WIDTH-1:0] q_now_time,
  input  logic [15:0]           q_query_handle,
  input  logic [15:0]           q_query_length,
  input  logic [15:0]           q_response_limit,
  input  logic [15:0]           q_response_id,
  input  logic [15:0]           q_packet_length,
  input  logic                  q_short,
  output logic                  back_take,
  input  logic [31:0]           interval,
  input  logic [7:0]            max_repeat,
  input  logic [15:0]           max_len,
  output logic                  out_strobe,
  output logic [3:0]            out_status,
  output logic [15:0]           out_handle,
  output logic [15:0]           out_query_id,
  output logic [15:0]           out_length,
  output logic                  out_wake_valid,
  output logic [TIME_WIDTH-1:0] out_wake_time
);

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int TW  = (ID_TRIES > 1) ? $clog2(ID_TRIES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_WAKE  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [15:0]            qid_m  [TABLE_DEPTH];
  logic [15:0]            hnd_m  [TABLE_DEPTH];
  logic [15:0]            qlen_m [TABLE_DEPTH];
  logic [15:0]            rlim_m [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0]  due_m  [TABLE_DEPTH];
  logic [8:0]             cnt_m  [TABLE_DEPTH];
  logic [31:0]            stamp_m[TABLE_DEPTH];

  logic [15:0] id_ctr_r;
  logic [31:0] stamp_ctr_r;

  logic [CW-1:0] idx_r;
  logic [TW-1:0] try_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          best_ok_r;
  logic [IW-1:0] best_r;
  logic [TIME_WIDTH-1:0] best_due_r;
  logic [31:0]   best_stamp_r;
  logic          free_ok_r;
  logic [IW-1:0] free_r;

  logic [3:0]  st_r;
  logic [15:0] oh_r, oid_r, olen_r;
  logic        strobe_r;

  logic [IW-1:0] idx;
  logic [15:0]   key;
  logic          last;
  logic          better;
  logic [31:0]   sdiff;
  logic          id_clash;
  logic          retry;

  assign idx  = idx_r[IW-1:0];
  assign last = (idx_r == CW'(TABLE_DEPTH - 1));
  assign key  = (q_command == CMD_NEW) ? id_ctr_r : q_response_id;
  assign sdiff = best_stamp_r - stamp_m[idx];
  assign better = !best_ok_r || (due_m[idx] < best_due_r) ||
                  ((due_m[idx] == best_due_r) && (sdiff != 32'd0) && !sdiff[31]);
  assign id_clash = valid_r[idx] && (qid_m[idx] == key);
  assign retry = (q_command == CMD_NEW) && last && (hit_r || id_clash) &&
                 (try_r != TW'(ID_TRIES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = (q_command == CMD_NOTICE ||
                  (q_command == CMD_RESP && q_short)) ? S_WAKE : S_SCAN;
      S_SCAN: if (last) state_nxt = retry ? S_SCAN : S_ACT;
      S_ACT:  state_nxt = S_WAKE;
      S_WAKE: if (last) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign back_take = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      id_ctr_r    <= '0;
      stamp_ctr_r <= '0;
      idx_r       <= '0;
      try_r       <= '0;
      strobe_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_OUT);
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          try_r <= '0;
          hit_r <= 1'b0;
          best_ok_r <= 1'b0;
          free_ok_r <= 1'b0;
          oh_r <= '0;
          oid_r <= '0;
          olen_r <= '0;
          if (q_command == CMD_NOTICE) begin
            st_r <= ST_NOTICE;
            oh_r <= q_query_handle;
          end else begin
            st_r <= ST_SHORT;
          end
        end
        S_SCAN: begin
          if (retry) begin
            try_r <= try_r + 1'b1;
            hit_r <= 1'b0;
            free_ok_r <= 1'b0;
          end else begin
            if (id_clash && !hit_r) begin
              hit_r <= 1'b1;
              hit_idx_r <= idx;
            end
            if (!valid_r[idx] && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r <= idx;
            end
          end
          if (valid_r[idx] && better) begin
            best_ok_r <= 1'b1;
            best_r <= idx;
            best_due_r <= due_m[idx];
            best_stamp_r <= stamp_m[idx];
          end
          if (last) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
          if (q_command == CMD_NEW && last && (hit_r || id_clash)) begin
            id_ctr_r <= id_ctr_r + 16'd1;
          end
        end
        S_ACT: begin
          best_ok_r <= 1'b0;
          case (q_command)
            CMD_NEW: begin
              oh_r <= q_query_handle;
              if (hit_r) begin
                st_r <= ST_NO_ID;
              end else if (!free_ok_r) begin
                st_r <= ST_FULL;
              end else begin
                st_r <= ST_ACCEPTED;
                oid_r <= id_ctr_r;
                id_ctr_r <= id_ctr_r + 16'd1;
                stamp_ctr_r <= stamp_ctr_r + 32'd1;
                valid_r[free_r] <= 1'b1;
              end
            end
            CMD_POLL: begin
              if (!best_ok_r || best_due_r > q_now_time) begin
                st_r <= ST_IDLE;
              end else begin
                oh_r <= hnd_m[best_r];
                oid_r <= qid_m[best_r];
                if (cnt_m[best_r] > {1'b0, max_repeat}) begin
                  st_r <= ST_RETRY;
                  valid_r[best_r] <= 1'b0;
                end else if (qlen_m[best_r] > max_len) begin
                  st_r <= ST_TOO_LONG;
                  valid_r[best_r] <= 1'b0;
                end else begin
                  st_r <= ST_SENT;
                  olen_r <= qlen_m[best_r];
                  stamp_ctr_r <= stamp_ctr_r + 32'd1;
                end
              end
            end
            default: begin
              if (!hit_r) begin
                st_r <= ST_UNKNOWN;
                oid_r <= q_response_id;
              end else begin
                oh_r <= hnd_m[hit_idx_r];
                oid_r <= qid_m[hit_idx_r];
                valid_r[hit_idx_r] <= 1'b0;
                if (q_packet_length > rlim_m[hit_idx_r]) begin
                  st_r <= ST_RESP_LONG;
                end else begin
                  st_r <= ST_POSTED;
                  olen_r <= q_packet_length;
                end
              end
            end
          endcase
        end
        S_WAKE: begin
          if (valid_r[idx] && better) begin
            best_ok_r <= 1'b1;
            best_r <= idx;
            best_due_r <= due_m[idx];
            best_stamp_r <= stamp_m[idx];
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACT) begin
      if (q_command == CMD_NEW && !hit_r && free_ok_r) begin
        qid_m[free_r]   <= id_ctr_r;
        hnd_m[free_r]   <= q_query_handle;
        qlen_m[free_r]  <= q_query_length;
        rlim_m[free_r]  <= q_response_limit;
        due_m[free_r]   <= q_now_time;
        cnt_m[free_r]   <= '0;
        stamp_m[free_r] <= stamp_ctr_r;
      end else if (q_command == CMD_POLL && best_ok_r && best_due_r <= q_now_time &&
                   cnt_m[best_r] <= {1'b0, max_repeat} && qlen_m[best_r] <= max_len) begin
        if (cnt_m[best_r] != 9'(CNT_MAX)) cnt_m[best_r] <= cnt_m[best_r] + 9'd1;
        due_m[best_r]   <= q_now_time + TIME_WIDTH'(interval);
        stamp_m[best_r] <= stamp_ctr_r;
      end
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = st_r;
  assign out_handle     = oh_r;
  assign out_query_id   = oid_r;
  assign out_length     = olen_r;
  assign out_wake_valid = best_ok_r;
  assign out_wake_time  = best_ok_r ? best_due_r : '0;

endmodule

[design/query_retransmit_tracker.sv]
// Top level of the query retransmit tracker: config registers, front and back.
// Depends on qrt_pkg, qrt_front, qrt_back.
//
//  channel | ports                       | handshake
//  in      | start, busy, in_*           | accept on start && !busy
//  out     | out_strobe, out_*           | one cycle, no backpressure
//  cfg     | cfg_valid, cfg_ready, cfg_* | accept on cfg_valid && cfg_ready
//
// A new query, poll or response runs one lookup scan, an action step and one wake
// scan from accept to the next accept, one entry a cycle in each scan. A short
// response or a notice skips the lookup scan and the action step.
// A new query whose id collides rescans once per retry, up to ID_TRIES lookup scans.
// busy drops in the strobe cycle; the receiver cannot stall.
// Reset is synchronous; the table needs no clearing pass.
module query_retransmit_tracker import qrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_TRIES    = 4,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  input  logic [15:0]           in_query_handle,
  input  logic [15:0]           in_query_length,
  input  logic [15:0]           in_response_limit,
  input  logic [15:0]           in_response_id,
  input  logic [15:0]           in_packet_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  out_strobe,
  output logic [3:0]            out_status,
  output logic [15:0]           out_handle,
  output logic [15:0]           out_query_id,
  output logic [15:0]           out_length,
  output logic                  out_wake_valid,
  output logic [TIME_WIDTH-1:0] out_wake_time
);

  logic [31:0] interval_r;
  logic [7:0]  repeat_r;
  logic [15:0] maxlen_r;

  logic                  q_valid, q_short, back_take;
  logic [1:0]            q_command;
  logic [TIME_WIDTH-1:0] q_now_time;
  logic [15:0]           q_handle, q_qlen, q_rlim, q_rid, q_plen;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 32'd1000000;
      repeat_r   <= 8'd3;
      maxlen_r   <= 16'd1536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_REPEAT:   repeat_r   <= cfg_data[7:0];
        CFG_MAXLEN:   maxlen_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  qrt_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_now_time, .in_query_handle, .in_query_length,
    .in_response_limit, .in_response_id, .in_packet_length,
    .back_take, .q_valid, .q_command, .q_now_time,
    .q_query_handle(q_handle), .q_query_length(q_qlen),
    .q_response_limit(q_rlim), .q_response_id(q_rid),
    .q_packet_length(q_plen), .q_short
  );

  qrt_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_TRIES(ID_TRIES),
             .TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_command, .q_now_time,
    .q_query_handle(q_handle), .q_query_length(q_qlen),
    .q_response_limit(q_rlim), .q_response_id(q_rid),
    .q_packet_length(q_plen), .q_short, .back_take,
    .interval(interval_r), .max_repeat(repeat_r), .max_len(maxlen_r),
    .out_strobe, .out_status, .out_handle, .out_query_id, .out_length,
    .out_wake_valid, .out_wake_time
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$past(out_strobe))
    else $error("strobe held two cycles");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");
  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_wake_valid) |-> (out_wake_time == '0))
    else $error("wake time nonzero when empty");

endmodule

[verif/qrt_checker.sv]
// Checker for the query retransmit tracker: watches in, cfg and out channels,
// predicts every result from its own model of the slot table and compares.
// Depends on qrt_pkg.
module qrt_checker import qrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [47:0] in_now_time,
  input  logic [15:0] in_query_handle,
  input  logic [15:0] in_query_length,
  input  logic [15:0] in_response_limit,
  input  logic [15:0] in_response_id,
  input  logic [15:0] in_packet_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_strobe,
  input  logic [3:0]  out_status,
  input  logic [15:0] out_handle,
  input  logic [15:0] out_query_id,
  input  logic [15:0] out_length,
  input  logic        out_wake_valid,
  input  logic [47:0] out_wake_time,
  output int          errors,
  output int          outstanding
);

  localparam int DEPTH = 16;
  localparam int TRIES = 4;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] handle;
    logic [15:0] query_id;
    logic [15:0] length;
    logic        wake_valid;
    logic [47:0] wake_time;
  } tracker_result_t;

  logic        live     [DEPTH];
  logic [15:0] qid      [DEPTH];
  logic [15:0] owner    [DEPTH];
  logic [15:0] qlen     [DEPTH];
  logic [15:0] rlim     [DEPTH];
  logic [47:0] due      [DEPTH];
  logic [8:0]  sends    [DEPTH];
  logic [31:0] stamp    [DEPTH];
  logic [15:0] next_id;
  logic [31:0] next_stamp;
  logic [31:0] interval;
  logic [7:0]  repeat_limit;
  logic [15:0] len_limit;

  tracker_result_t expected_results[$];

  function automatic int find_id(logic [15:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (live[i] && qid[i] == id) return i;
    return -1;
  endfunction

  function automatic int earliest_due();
    int best;
    logic [31:0] d;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!live[i]) continue;
      if (best < 0 || due[i] < due[best]) begin
        best = i;
      end else if (due[i] == due[best]) begin
        d = stamp[best] - stamp[i];
        if (d != 32'd0 && d < 32'h8000_0000) best = i;
      end
    end
    return best;
  endfunction

  function automatic tracker_result_t track_transaction(
      logic [1:0] cmd, logic [47:0] now, logic [15:0] hnd, logic [15:0] len,
      logic [15:0] lim, logic [15:0] rid, logic [15:0] plen);
    tracker_result_t r;
    bit found;
    int s;
    r = '0;
    case (cmd)
      CMD_NEW: begin
        r.handle = hnd;
        found = 1'b0;
        for (int t = 0; t < TRIES; t++)
          if (!found) begin
            if (find_id(next_id) < 0) found = 1'b1;
            else next_id++;
          end
        if (!found) begin
          r.status = ST_NO_ID;
        end else begin
          s = -1;
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!live[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            live[s] = 1'b1; qid[s] = next_id; owner[s] = hnd; qlen[s] = len;
            rlim[s] = lim; due[s] = now; sends[s] = '0; stamp[s] = next_stamp;
            next_stamp++;
            r.query_id = next_id;
            next_id++;
            r.status = ST_ACCEPTED;
          end
        end
      end
      CMD_POLL: begin
        s = earliest_due();
        if (s < 0 || due[s] > now) begin
          r.status = ST_IDLE;
        end else begin
          r.handle = owner[s];
          r.query_id = qid[s];
          if (sends[s] > {1'b0, repeat_limit}) begin
            live[s] = 1'b0; r.status = ST_RETRY;
          end else if (qlen[s] > len_limit) begin
            live[s] = 1'b0; r.status = ST_TOO_LONG;
          end else begin
            r.length = qlen[s];
            if (sends[s] < 9'(CNT_MAX)) sends[s]++;
            due[s] = now + {16'd0, interval};
            stamp[s] = next_stamp;
            next_stamp++;
            r.status = ST_SENT;
          end
        end
      end
      CMD_RESP: begin
        if (plen < 16'd2) begin
          r.status = ST_SHORT;
        end else begin
          s = find_id(rid);
          if (s < 0) begin
            r.status = ST_UNKNOWN;
            r.query_id = rid;
          end else begin
            r.handle = owner[s];
            r.query_id = qid[s];
            if (plen > rlim[s]) begin
              r.status = ST_RESP_LONG;
            end else begin
              r.status = ST_POSTED;
              r.length = plen;
            end
            live[s] = 1'b0;
          end
        end
      end
      default: begin
        r.status = ST_NOTICE;
        r.handle = hnd;
      end
    endcase
    s = earliest_due();
    r.wake_valid = (s >= 0);
    r.wake_time = (s >= 0) ? due[s] : '0;
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
      next_id = '0;
      next_stamp = '0;
      interval = 32'd1000000;
      repeat_limit = 8'd3;
      len_limit = 16'd1536;
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, out_status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_handle !== e.handle) begin
            $display("%0t: handle expected %h actual %h", $time, e.handle, out_handle);
            errors++;
          end
          if (out_query_id !== e.query_id) begin
            $display("%0t: query id expected %h actual %h", $time, e.query_id,
                     out_query_id);
            errors++;
          end
          if (out_length !== e.length) begin
            $display("%0t: length expected %h actual %h", $time, e.length, out_length);
            errors++;
          end
          if (out_wake_valid !== e.wake_valid) begin
            $display("%0t: wake valid expected %b actual %b", $time, e.wake_valid,
                     out_wake_valid);
            errors++;
          end
          if (out_wake_time !== e.wake_time) begin
            $display("%0t: wake time expected %h actual %h", $time, e.wake_time,
                     out_wake_time);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERVAL: interval = cfg_data;
          CFG_REPEAT:   repeat_limit = cfg_data[7:0];
          CFG_MAXLEN:   len_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.push_back(track_transaction(in_command, in_now_time,
            in_query_handle, in_query_length, in_response_limit, in_response_id,
            in_packet_length));
    end
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the query retransmit tracker: clock, reset, stimulus and verdict.
// Depends on qrt_pkg, query_retransmit_tracker and qrt_checker.
module tb_top import qrt_pkg::*;;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_command = CMD_NOTICE;
  logic [47:0] in_now_time = '0;
  logic [15:0] in_query_handle = '0;
  logic [15:0] in_query_length = '0;
  logic [15:0] in_response_limit = '0;
  logic [15:0] in_response_id = '0;
  logic [15:0] in_packet_length = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_INTERVAL;
  logic [31:0] cfg_data = '0;
  logic        out_strobe;
  logic [3:0]  out_status;
  logic [15:0] out_handle;
  logic [15:0] out_query_id;
  logic [15:0] out_length;
  logic        out_wake_valid;
  logic [47:0] out_wake_time;
  int          errors;
  int          outstanding;
  int          cycles = 0;
  logic [47:0] clock_now = '0;
  logic [15:0] live_ids[$];

  always #5 clk = ~clk;

  query_retransmit_tracker dut (.*);
  qrt_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // track ids in flight so responses can hit them
  always @(posedge clk) begin
    int idx[$];
    if (out_strobe) begin
      if (out_status == ST_ACCEPTED) begin
        live_ids.push_back(out_query_id);
      end else if (out_status inside {ST_RETRY, ST_TOO_LONG, ST_POSTED, ST_RESP_LONG}) begin
        idx = live_ids.find_first_index(x) with (x == out_query_id);
        if (idx.size() > 0) live_ids.delete(idx[0]);
      end
    end
  end

  task automatic issue(logic [1:0] cmd, logic [47:0] now, logic [15:0] hnd,
                       logic [15:0] len, logic [15:0] lim, logic [15:0] rid,
                       logic [15:0] plen);
    start <= 1;
    in_command <= cmd;
    in_now_time <= now;
    in_query_handle <= hnd;
    in_query_length <= len;
    in_response_limit <= lim;
    in_response_id <= rid;
    in_packet_length <= plen;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [15:0] rid;
    logic [15:0] len;
    logic [15:0] plen;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_now = 48'({$urandom, $urandom});
    else clock_now = clock_now + 48'($urandom_range(0, 400000));
    len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1)) :
           ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(2, 800));
    rid = (live_ids.size() > 0 && $urandom_range(0, 4) != 0) ?
          live_ids[$urandom_range(0, live_ids.size() - 1)] : 16'($urandom);
    if (pick < 35)
      issue(CMD_NEW, clock_now, 16'($urandom), len,
            ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(300, 65535)),
            16'($urandom), 16'($urandom));
    else if (pick < 65)
      issue(CMD_POLL, clock_now, 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
    else if (pick < 95)
      issue(CMD_RESP, clock_now, 16'($urandom), 16'($urandom), 16'($urandom), rid, plen);
    else
      issue(CMD_NOTICE, clock_now, 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] ids[$];
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    issue(CMD_POLL, 48'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    issue(CMD_NEW, 48'd0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0);
    issue(CMD_POLL, 48'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    issue(CMD_POLL, 48'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    for (int k = 1; k <= 4; k++)
      issue(CMD_POLL, 48'(k * 1000000), 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    issue(CMD_NEW, 48'hFFFF_FFFF_FFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0);
    issue(CMD_POLL, 48'hFFFF_FFFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    issue(CMD_NEW, 48'd5, 16'h1234, 16'd1, 16'd0, 16'h0, 16'h0);
    issue(CMD_NEW, 48'd5, 16'h4321, 16'd2, 16'hFFFF, 16'h0, 16'h0);
    issue(CMD_RESP, 48'd6, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'd0);
    issue(CMD_RESP, 48'd6, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'd1);
    issue(CMD_RESP, 48'd6, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
    issue(CMD_NOTICE, 48'd6, 16'hA5A5, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();
    ids = live_ids;
    foreach (ids[k])
      issue(CMD_RESP, 48'd7, 16'h0, 16'h0, 16'h0, ids[k], 16'd2 + 16'(k));
    for (int k = 0; k < 17; k++)
      issue(CMD_NEW, 48'd8, 16'(k), 16'(k), 16'hFFFF, 16'h0, 16'h0);
    drain();
    ids = live_ids;
    foreach (ids[k])
      issue(CMD_RESP, 48'd9, 16'h0, 16'h0, 16'h0, ids[k], 16'hFFFF);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_INTERVAL, 32'd1);
          write_reg(CFG_REPEAT, 32'd0);
          write_reg(CFG_MAXLEN, 32'd2);
        end
        1: begin
          write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
          write_reg(CFG_REPEAT, 32'd255);
          write_reg(CFG_MAXLEN, 32'd65535);
        end
        2: begin
          write_reg(CFG_INTERVAL, $urandom_range(1000, 2000000));
          write_reg(CFG_REPEAT, $urandom_range(0, 6));
          write_reg(CFG_MAXLEN, $urandom_range(2, 2000));
        end
        default: begin
          write_reg(CFG_INTERVAL, 32'd1000000);
          write_reg(CFG_REPEAT, 32'd3);
          write_reg(CFG_MAXLEN, 32'd1536);
        end
      endcase
      for (int n = 0; n < 460; n++) begin
        random_item();
        if (ph < 3 && $urandom_range(0, 3) == 0) begin
          start <= 0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/qrt_pkg.sv
design/qrt_front.sv
design/qrt_back.sv
design/query_retransmit_tracker.sv
verif/qrt_checker.sv
verif/tb_top.sv
